FILE: src/lat_pkg.sv
package lat_pkg;

   // Largest grid side the storage holds.
   localparam int MAX_SIDE = 64;
   localparam int ROW_W    = $clog2(MAX_SIDE);
   // Width of the side register and of the clamped side in use.
   localparam int SIDE_W   = 7;
   // A cell has eight neighbor terms, so the count fits in four bits.
   localparam int COUNT_W  = 4;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIDE_ADDR = CSR_ADDR_W'(0);
   localparam logic [SIDE_W-1:0]     SIDE_RESET    = SIDE_W'(MAX_SIDE);

   typedef logic [MAX_SIDE-1:0] row_type;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_ADVANCE = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

endpackage

FILE: src/lat_ram.sv
module lat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lat_row_next.sv
// Next generation of one grid row, one lane per column. Columns wrap at the
// side in use; columns beyond it keep their stored value.
module lat_row_next (
   input  lat_pkg::row_type            prev_row,
   input  lat_pkg::row_type            cur_row,
   input  lat_pkg::row_type            next_row,
   input  logic [lat_pkg::SIDE_W-1:0]  side,
   output lat_pkg::row_type            new_row
);
   import lat_pkg::*;

   logic [ROW_W-1:0] last_col;
   logic [2:0]       wrap_left;
   logic [2:0]       wrap_right;

   assign last_col   = ROW_W'(side - SIDE_W'(1));
   assign wrap_left  = {prev_row[last_col], cur_row[last_col], next_row[last_col]};
   assign wrap_right = {prev_row[0], cur_row[0], next_row[0]};

   for (genvar c = 0; c < MAX_SIDE; c++) begin : g_lane
      logic [2:0]         lft;
      logic [2:0]         rgt;
      logic [COUNT_W-1:0] cnt;
      logic               alive;
      logic               in_use;

      if (c == 0) begin : g_first
         assign lft = wrap_left;
      end else begin : g_inner
         assign lft = {prev_row[c-1], cur_row[c-1], next_row[c-1]};
      end

      assign rgt = (ROW_W'(c) == last_col) ? wrap_right :
                   {prev_row[(c+1)%MAX_SIDE], cur_row[(c+1)%MAX_SIDE],
                    next_row[(c+1)%MAX_SIDE]};

      assign cnt = COUNT_W'(lft[2]) + COUNT_W'(lft[1]) + COUNT_W'(lft[0])
                 + COUNT_W'(rgt[2]) + COUNT_W'(rgt[1]) + COUNT_W'(rgt[0])
                 + COUNT_W'(prev_row[c]) + COUNT_W'(next_row[c]);

      assign alive  = cur_row[c];
      assign in_use = (SIDE_W'(c) < side);

      assign new_row[c] = in_use ? ((cnt == COUNT_W'(3)) || (alive && cnt == COUNT_W'(2)))
                                 : alive;
   end

endmodule

FILE: src/life_automaton_torus_unit.sv
// Toroidal Game of Life grid. Each request beat writes one cell, reads one
// cell, advances the whole grid by one generation or does nothing (NOP),
// and each gives exactly one response beat (the read value, or 0, plus an
// echo of the operation). The grid is stored one row per word in a single
// 64 x 64 synchronous RAM; a per-row valid flag makes every row read as
// dead after reset, so there is no clearing pass. A write or read uses the
// accepting cycle, which issues the RAM read, then S_ACCESS, which writes
// the row back and loads the response beat. A generation uses the
// accepting cycle, then PRE0, PRE1 and PRE2 to prime the row window (last
// row, row 0, row 1), then one S_ROW step per row, bounded by the single
// RAM read port. Rows are rewritten in place; the original row 0 is kept
// aside for the wrap at the bottom edge. Requests are taken one at a time;
// a new request beat is accepted only once the previous response beat has
// left, or in the cycle in which it leaves. The side register (APB,
// address 0) must only be written while the block is idle.
module life_automaton_torus_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic [lat_pkg::ROW_W-1:0]        req_row_index,
   input  logic [lat_pkg::ROW_W-1:0]        req_col_index,
   input  logic                             req_cell_in,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_cell_out,
   output logic [1:0]                       rsp_done_func,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lat_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lat_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lat_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import lat_pkg::*;

   // Sequencer states. PRE0..PRE2 fill the three-row window of a generation.
   typedef enum logic [2:0] {
      S_IDLE,
      S_ACCESS,
      S_PRE0,
      S_PRE1,
      S_PRE2,
      S_ROW
   } state_type;

   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROW_W-1:0]     col_ff, col_in;
   logic                 cell_in_ff, cell_in_in;
   logic [ROW_W-1:0]     gen_row_ff, gen_row_in;
   row_type              prev_ff, prev_in;
   row_type              cur_ff, cur_in;
   row_type              row0_ff, row0_in;
   logic [MAX_SIDE-1:0]  row_valid_ff, row_valid_in;
   logic                 rd_valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_cell_ff, rsp_cell_in;
   func_type             rsp_func_ff, rsp_func_in;
   logic [SIDE_W-1:0]    side_ff, side_in;

   logic [SIDE_W-1:0]    side_use;
   logic                 accept;
   logic                 csr_write;
   logic                 in_grid;
   logic                 last_row;
   logic [SIDE_W:0]      plus_two;
   logic [ROW_W-1:0]     ahead_row;
   logic [ROW_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_addr;
   row_type              wr_data;
   row_type              ram_rd_data;
   row_type              rd_row;
   row_type              next_row;
   row_type              new_row;
   row_type              cell_row;

   // A side of zero is used as one; anything past the storage is clamped.
   always_comb begin
      priority if (side_ff == '0) begin
         side_use = SIDE_W'(1);
      end else if (side_ff > SIDE_W'(MAX_SIDE)) begin
         side_use = SIDE_W'(MAX_SIDE);
      end else begin
         side_use = side_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr == CSR_SIDE_ADDR);

   // Rows that were never written since reset read as all dead.
   assign rd_row = ram_rd_data & {MAX_SIDE{rd_valid_ff}};

   assign in_grid = (SIDE_W'(row_ff) < side_use) && (SIDE_W'(col_ff) < side_use);

   // During a sweep, the row below the last one is the saved original row 0,
   // since row 0 has already been rewritten by then.
   assign last_row  = (SIDE_W'(gen_row_ff) + SIDE_W'(1)) == side_use;
   assign next_row  = last_row ? row0_ff : rd_row;
   assign plus_two  = (SIDE_W+1)'(gen_row_ff) + (SIDE_W+1)'(2);
   assign ahead_row = (plus_two >= (SIDE_W+1)'(side_use))
                      ? ROW_W'(plus_two - (SIDE_W+1)'(side_use))
                      : ROW_W'(plus_two);

   always_comb begin
      cell_row         = rd_row;
      cell_row[col_ff] = cell_in_ff;
   end

   lat_row_next u_row_next (
      .prev_row (prev_ff),
      .cur_row  (cur_ff),
      .next_row (next_row),
      .side     (side_use),
      .new_row  (new_row)
   );

   lat_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cell_in_in   = cell_in_ff;
      gen_row_in   = gen_row_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      row0_in      = row0_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_func_in  = rsp_func_ff;
      side_in      = side_ff;
      rd_addr      = req_row_index;
      wr_en        = 1'b0;
      wr_addr      = gen_row_ff;
      wr_data      = new_row;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         side_in = csr_pwdata[SIDE_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in    = func_type'(req_func);
               row_in     = req_row_index;
               col_in     = req_col_index;
               cell_in_in = req_cell_in;
               unique case (func_type'(req_func))
                  FUNC_WRITE, FUNC_READ: begin
                     state_in = S_ACCESS;
                  end
                  FUNC_ADVANCE: begin
                     state_in = S_PRE0;
                  end
                  FUNC_NOP: begin
                     rsp_valid_in = 1'b1;
                     rsp_cell_in  = 1'b0;
                     rsp_func_in  = FUNC_NOP;
                  end
               endcase
            end
         end
         S_ACCESS: begin
            // The row addressed at accept is on the RAM output now.
            if (func_ff == FUNC_WRITE && in_grid) begin
               wr_en   = 1'b1;
               wr_addr = row_ff;
               wr_data = cell_row;
               row_valid_in[row_ff] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            rsp_cell_in  = (func_ff == FUNC_READ) && in_grid && rd_row[col_ff];
            rsp_func_in  = func_ff;
            state_in     = S_IDLE;
         end
         S_PRE0: begin
            rd_addr  = ROW_W'(side_use - SIDE_W'(1));
            state_in = S_PRE1;
         end
         S_PRE1: begin
            rd_addr  = '0;
            prev_in  = rd_row;
            state_in = S_PRE2;
         end
         S_PRE2: begin
            rd_addr    = (side_use == SIDE_W'(1)) ? '0 : ROW_W'(1);
            cur_in     = rd_row;
            row0_in    = rd_row;
            gen_row_in = '0;
            state_in   = S_ROW;
         end
         S_ROW: begin
            // Write back the new row while fetching two rows ahead.
            wr_en   = 1'b1;
            wr_addr = gen_row_ff;
            wr_data = new_row;
            row_valid_in[gen_row_ff] = 1'b1;
            rd_addr = ahead_row;
            prev_in = cur_ff;
            cur_in  = next_row;
            if (last_row) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = 1'b0;
               rsp_func_in  = FUNC_ADVANCE;
               state_in     = S_IDLE;
            end else begin
               gen_row_in = gen_row_ff + ROW_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         side_ff      <= SIDE_RESET;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         side_ff      <= side_in;
      end
      func_ff     <= func_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cell_in_ff  <= cell_in_in;
      gen_row_ff  <= gen_row_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      row0_ff     <= row0_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_func_ff <= rsp_func_in;
      // The valid flag is sampled together with the read, so it matches the
      // data that the RAM returns next cycle.
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_out  = rsp_cell_ff;
   assign rsp_done_func = rsp_func_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_SIDE_ADDR) ? CSR_DATA_W'(side_ff) : '0;

   // The response register is always free while an operation is in flight.
   a_slot_free_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while an operation is in flight");

   // No write ever lands outside the grid in use.
   a_write_in_grid: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (SIDE_W'(wr_addr) < side_use))
      else $error("grid write outside the side in use");

   // The sweep row counter never runs past the last row.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> (SIDE_W'(gen_row_ff) < side_use))
      else $error("generation sweep past the last row");

   // The saved copy of row 0 is the row the sweep starts on.
   a_row0_saved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW && gen_row_ff == '0) |-> (row0_ff == cur_ff))
      else $error("saved row 0 differs from the first swept row");

   // Memory is never written outside of a cell access or a sweep row.
   a_no_stray_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_PRE0 || state_ff == S_PRE1
       || state_ff == S_PRE2) |-> !wr_en)
      else $error("grid write outside an access or sweep row");

endmodule
